// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the clock, masked while reset is active.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the clock, also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tre_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tre_pkg
// Types and constants shared by the TFTP receive engine modules.
// ============================================================================
package tre_pkg;

    // Input item modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_PKT   = 2'd1;
    localparam logic [1:0] MODE_TIMER = 2'd2;
    localparam logic [1:0] MODE_ABORT = 2'd3;

    // TFTP opcodes and length limits.
    localparam logic [15:0] OP_DATA      = 16'd3;
    localparam logic [15:0] OP_ERROR     = 16'd5;
    localparam logic [9:0]  MIN_PKT_LEN  = 10'd2;
    localparam logic [9:0]  MIN_DATA_LEN = 10'd4;
    localparam logic [9:0]  MIN_ERR_LEN  = 10'd5;
    localparam logic [9:0]  HDR_LEN      = 10'd4;

    // Classified events handed from the front to the back.
    localparam logic [2:0] EV_NOP   = 3'd0;
    localparam logic [2:0] EV_START = 3'd1;
    localparam logic [2:0] EV_DATA  = 3'd2;
    localparam logic [2:0] EV_ERR   = 3'd3;
    localparam logic [2:0] EV_TIMER = 3'd4;
    localparam logic [2:0] EV_ABORT = 3'd5;

    // Protocol states, as shown on link_state.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_REQ   = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_ABORT = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    // Packet kinds to send.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_RRQ   = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // End status codes.
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_DONE    = 2'd1;
    localparam logic [1:0] END_TIMEOUT = 2'd2;
    localparam logic [1:0] END_PEER    = 2'd3;

    // Configuration register indexes and reset values.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TIMEOUT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES     = 2'd3;
    localparam logic [15:0] DEF_INITIAL_TIMEOUT = 16'd4000;
    localparam logic [15:0] DEF_MAX_TIMEOUT     = 16'd16000;
    localparam logic [7:0]  DEF_MAX_RETRIES     = 8'd8;
    localparam logic [9:0]  DEF_BLOCK_BYTES     = 10'd512;

    localparam logic [7:0]  RETRY_MAX = 8'hFF;

    // Division of the round-trip average by ten: ceil(2^23 / 10), exact
    // for every sum below 2^22.
    localparam logic [19:0] RECIP10     = 20'd838861;
    localparam int          DIV10_SHIFT = 23;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [9:0]  packet_length;
        logic [15:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic        arm_timer;
        logic [15:0] timer_value;
        logic [2:0]  link_state;
        logic        payload_accept;
        logic [9:0]  payload_bytes;
        logic [1:0]  end_status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] initial_timeout;
        logic [15:0] max_timeout;
        logic [7:0]  max_retries;
        logic [9:0]  block_bytes;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] block_number;
        logic [9:0]  payload_bytes;
        logic [15:0] elapsed;
    } t_cmd;

endpackage

// ===== design/tre_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tre_fifo
// Small register queue with simultaneous push and pop.
// ============================================================================
module tre_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage is written only at the write pointer.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/tre_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tre_front
// Accepts input items, sorts them into events and queues them for the back.
// ============================================================================
module tre_front
    import tre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_cmd_pop,
    output t_cmd     o_cmd,
    output logic     o_cmd_empty
);

    t_cmd cmd;

    // Classify the item by mode, opcode and length; state checks come later.
    always_comb begin
        cmd.block_number  = i_item.block_number;
        cmd.payload_bytes = i_item.packet_length - HDR_LEN;
        cmd.elapsed       = i_item.elapsed;
        case (i_item.mode)
            MODE_START: begin
                cmd.ev = EV_START;
            end
            MODE_PKT: begin
                if (i_item.packet_length >= MIN_PKT_LEN && i_item.opcode == OP_DATA &&
                    i_item.packet_length >= MIN_DATA_LEN) begin
                    cmd.ev = EV_DATA;
                end else if (i_item.packet_length >= MIN_PKT_LEN &&
                             i_item.opcode == OP_ERROR &&
                             i_item.packet_length >= MIN_ERR_LEN) begin
                    cmd.ev = EV_ERR;
                end else begin
                    cmd.ev = EV_NOP;
                end
            end
            MODE_TIMER: begin
                cmd.ev = EV_TIMER;
            end
            default: begin
                cmd.ev = EV_ABORT;
            end
        endcase
    end

    // Event queue toward the back.
    tre_fifo #(
        .T     (t_cmd),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

// ===== design/tre_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tre_back
// Protocol state machine: executes one event per cycle while the result queue has room, and queues results.
// ============================================================================
module tre_back
    import tre_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output t_out_item o_result,
    output logic      o_empty
);

    // Interval values never exceed 16 bits, so wider timers add no storage.
    localparam int            IW    = (TIMER_BITS < 16) ? TIMER_BITS : 16;
    localparam logic [IW-1:0] LIMIT = '1;

    logic [2:0]    r_state,  n_state;
    logic [15:0]   r_exp,    n_exp;
    logic [IW-1:0] r_iv,     n_iv;
    logic [7:0]    r_retry,  n_retry;
    t_out_item     res;
    logic          res_full;
    logic          fire;
    logic          retry_out;
    logic [7:0]    retry_bump;
    logic [IW-1:0] init_iv;
    logic [IW-1:0] avg_iv;
    logic [IW-1:0] dbl_iv;
    logic          dbl_hit;
    logic          live;

    // Saturate a 16-bit interval to the timer width.
    function automatic logic [IW-1:0] sat16(input logic [15:0] v);
        if (v > 16'(LIMIT)) begin
            return LIMIT;
        end
        return IW'(v);
    endfunction

    // Doubled interval, clamped at the ceiling.
    function automatic logic [IW-1:0] dbl_val(input logic [IW-1:0] iv,
                                              input logic [15:0] mx);
        logic [16:0] d;
        d = 17'(iv) << 1;
        if (d > {1'b0, mx}) begin
            return sat16(mx);
        end
        return sat16(d[15:0]);
    endfunction

    function automatic logic dbl_clamped(input logic [IW-1:0] iv,
                                         input logic [15:0] mx);
        logic [16:0] d;
        d = 17'(iv) << 1;
        return d > {1'b0, mx};
    endfunction

    // Round-trip average (9 * interval + elapsed) / 10, at least one.
    function automatic logic [IW-1:0] avg_val(input logic [IW-1:0] iv,
                                              input logic [15:0] el);
        logic [19:0] s;
        logic [39:0] p;
        logic [15:0] q;
        s = (20'(iv) << 3) + 20'(iv) + 20'(el);
        p = 40'(s) * 40'(RECIP10);
        q = p[DIV10_SHIFT +: 16];
        if (q == '0) begin
            q = 16'd1;
        end
        return sat16(q);
    endfunction

    assign fire       = !i_cmd_empty && !res_full;
    assign o_cmd_pop  = fire;
    assign retry_out  = (r_retry >= i_cfg.max_retries);
    assign retry_bump = (r_retry != RETRY_MAX) ? r_retry + 1'b1 : r_retry;
    assign init_iv    = sat16(i_cfg.initial_timeout);
    assign avg_iv     = avg_val(r_iv, i_cmd.elapsed);
    assign dbl_iv     = dbl_val(r_iv, i_cfg.max_timeout);
    assign dbl_hit    = dbl_clamped(r_iv, i_cfg.max_timeout);
    assign live       = (r_state == ST_REQ) || (r_state == ST_RUN);

    // Next state and result of the event at the head of the queue.
    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_iv    = r_iv;
        n_retry = r_retry;
        res     = '0;
        case (i_cmd.ev)
            EV_START: begin
                n_exp           = 16'd1;
                n_state         = ST_REQ;
                res.send_kind   = KIND_RRQ;
                res.arm_timer   = 1'b1;
                res.timer_value = 16'(init_iv);
                n_iv            = dbl_val(init_iv, i_cfg.max_timeout);
                n_retry         = 8'd1;
            end
            EV_DATA: begin
                if (live && i_cmd.block_number == r_exp) begin
                    n_state            = ST_RUN;
                    res.send_kind      = KIND_ACK;
                    res.send_block     = i_cmd.block_number;
                    n_iv               = avg_iv;
                    res.arm_timer      = 1'b1;
                    res.timer_value    = 16'(avg_iv);
                    res.payload_accept = 1'b1;
                    res.payload_bytes  = i_cmd.payload_bytes;
                    n_exp              = r_exp + 1'b1;
                    n_retry            = '0;
                    // A short block is the last one.
                    if (i_cmd.payload_bytes < i_cfg.block_bytes) begin
                        n_state        = ST_IDLE;
                        res.end_status = END_DONE;
                    end
                end
            end
            EV_ERR: begin
                if (live) begin
                    n_state        = ST_ERR;
                    res.end_status = END_PEER;
                end else if (r_state == ST_ABORT) begin
                    n_state = ST_IDLE;
                end
            end
            EV_TIMER: begin
                case (r_state)
                    ST_REQ: begin
                        if (retry_out) begin
                            n_state        = ST_IDLE;
                            res.end_status = END_TIMEOUT;
                        end else begin
                            res.send_kind   = KIND_RRQ;
                            res.arm_timer   = 1'b1;
                            res.timer_value = 16'(r_iv);
                            n_iv            = dbl_iv;
                            n_retry         = retry_bump;
                        end
                    end
                    ST_RUN: begin
                        if (retry_out) begin
                            res.end_status  = END_TIMEOUT;
                            n_state         = ST_ABORT;
                            n_iv            = IW'(1);
                            n_retry         = '0;
                            res.arm_timer   = 1'b1;
                            res.timer_value = 16'd1;
                        end else begin
                            res.send_kind   = KIND_ACK;
                            res.send_block  = r_exp - 1'b1;
                            n_iv            = dbl_iv;
                            res.arm_timer   = 1'b1;
                            res.timer_value = 16'(dbl_iv);
                            if (dbl_hit) begin
                                n_retry = retry_bump;
                            end
                        end
                    end
                    ST_ABORT: begin
                        if (retry_out) begin
                            n_state = ST_IDLE;
                        end else begin
                            res.send_kind   = KIND_ERROR;
                            n_iv            = dbl_iv;
                            res.arm_timer   = 1'b1;
                            res.timer_value = 16'(dbl_iv);
                            if (dbl_hit) begin
                                n_retry = retry_bump;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            EV_ABORT: begin
                if (r_state == ST_RUN) begin
                    n_state         = ST_ABORT;
                    n_iv            = IW'(1);
                    n_retry         = '0;
                    res.arm_timer   = 1'b1;
                    res.timer_value = 16'd1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
            end
        endcase
        res.link_state = n_state;
    end

    // Protocol state registers, updated only when an event executes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_exp   <= 16'd1;
            r_iv    <= sat16(DEF_INITIAL_TIMEOUT);
            r_retry <= '0;
        end else if (fire) begin
            r_state <= n_state;
            r_exp   <= n_exp;
            r_iv    <= n_iv;
            r_retry <= n_retry;
        end
    end

    // Result queue toward the consumer.
    tre_fifo #(
        .T     (t_out_item),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

// ===== design/tftp_receive_engine_top.sv =====
`timescale 1ns / 1ps
// Path: an accepted item enters the event queue; the back stage executes it from
// the queue head and writes its result into the result queue, whose head is shown.
// Throughput: one item per cycle while the result queue has room; the back stage
// (state update and round-trip average multiply) executes one event each such cycle.
// Reset: synchronous, active low; empties both queues, puts the protocol in idle
// and loads the configuration registers with their default values.
// ============================================================================
// tftp_receive_engine_top
// Receive engine of a TFTP read client: configuration, front and back stages.
// ============================================================================
module tftp_receive_engine_top
    import tre_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    input  t_in_item               i_item,
    output logic                   full,
    output logic                   empty,
    input  logic                   pop,
    output t_out_item              o_result,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_timeout <= DEF_INITIAL_TIMEOUT;
            r_cfg.max_timeout     <= DEF_MAX_TIMEOUT;
            r_cfg.max_retries     <= DEF_MAX_RETRIES;
            r_cfg.block_bytes     <= DEF_BLOCK_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INITIAL_TIMEOUT: r_cfg.initial_timeout <= i_cfg_data;
                REG_MAX_TIMEOUT:     r_cfg.max_timeout     <= i_cfg_data;
                REG_MAX_RETRIES:     r_cfg.max_retries     <= i_cfg_data[7:0];
                REG_BLOCK_BYTES:     r_cfg.block_bytes     <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Front: classification and event queue.
    tre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    // Back: protocol execution and result queue.
    tre_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_result    (o_result),
        .o_empty     (empty)
    );

endmodule

// ===== design/tre_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ============================================================================
// tre_checker
// Port-level checks of the TFTP receive engine, bound to the top level.
// ============================================================================
module tre_checker
    import tre_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_full,
    input logic      i_empty,
    input logic      i_pop,
    input t_out_item i_result
);

    // Reset leaves both queues empty.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (i_empty && !i_full), "queues not empty after reset")

    // A waiting result holds until it is taken.
    `ASSERT_RST(a_result_hold, i_clk, i_rst_n, (!i_empty && !i_pop) |=> (!i_empty && $stable(i_result)), "result changed while waiting")

    // An accepted payload is always acknowledged with the timer rearmed.
    `ASSERT_RST(a_accept_ack, i_clk, i_rst_n, (!i_empty && i_result.payload_accept) |-> (i_result.send_kind == KIND_ACK && i_result.arm_timer), "payload accepted without ACK")

    // A peer error leaves the link in the error state.
    `ASSERT_RST(a_peer_error, i_clk, i_rst_n, (!i_empty && i_result.end_status == END_PEER) |-> (i_result.link_state == ST_ERR), "peer error without error state")

endmodule

bind tftp_receive_engine_top tre_checker u_tre_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

// ===== dv/tftp_receive_engine_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tftp_receive_engine_top_test
// Self-checking bench for the TFTP read-client receive engine. A short table
// of directed items opens the run, followed by configuration phases of
// random, mostly well-formed transfers. Every accepted item is run through
// a behavioral copy of the engine and the produced result is compared field
// by field with the oldest outstanding expectation.
// ============================================================================
module tftp_receive_engine_top_test;
    import tre_pkg::*;

    localparam int ITEMS_PER_PHASE = 165;
    localparam int N_PHASES        = 8;
    localparam int HOLD_CYCLES     = 300;

    typedef struct {
        t_in_item  stim;
        logic      known;
        t_out_item want;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    t_in_item               i_item;
    logic                   full;
    logic                   empty;
    logic                   pop;
    t_out_item              o_result;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Expectation attached to the item on the input ports, if typed in.
    logic                   row_known;
    t_out_item              row_want;

    // Behavioral copy of the engine configuration and state.
    logic [15:0] cfg_init;
    logic [15:0] cfg_max;
    logic [7:0]  cfg_retries;
    logic [9:0]  cfg_blk;
    logic [2:0]  eng_state;
    logic [15:0] next_block;
    logic [15:0] rto;
    logic [7:0]  retries;
    logic [31:0] rx_bytes;

    t_out_item awaited_results[$];
    int        error_count    = 0;
    int        accepted_items = 0;
    int        hold_requests  = 0;
    int        burst_left     = 0;
    logic      rx_holding;

    tftp_receive_engine_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock, 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Doubles the retransmit interval up to the ceiling; returns 1 when clamped.
    function automatic bit double_rto();
        logic [16:0] d;
        d = {rto, 1'b0};
        if (d > {1'b0, cfg_max}) begin
            rto = cfg_max;
            return 1'b1;
        end
        rto = d[15:0];
        return 1'b0;
    endfunction

    function automatic void bump_retries();
        if (retries < RETRY_MAX) retries = retries + 8'd1;
    endfunction

    // Advances the engine copy by one item and returns the result it yields.
    function automatic t_out_item predict_engine_result(input t_in_item it);
        t_out_item   r;
        logic [9:0]  datalen;
        logic [20:0] avg;
        logic        live;
        r = '0;
        case (it.mode)
            MODE_START: begin
                next_block    = 16'd1;
                rx_bytes      = 32'd0;
                eng_state     = ST_REQ;
                r.send_kind   = KIND_RRQ;
                r.arm_timer   = 1'b1;
                r.timer_value = cfg_init;
                rto           = cfg_init;
                void'(double_rto());
                retries       = 8'd1;
            end
            MODE_PKT: begin
                live = (eng_state == ST_RUN) || (eng_state == ST_REQ);
                if (it.packet_length >= MIN_PKT_LEN &&
                    (live || (eng_state == ST_ABORT && it.opcode == OP_ERROR))) begin
                    if (it.opcode == OP_DATA && it.packet_length >= MIN_DATA_LEN &&
                        it.block_number == next_block) begin
                        datalen   = it.packet_length - HDR_LEN;
                        eng_state = ST_RUN;
                        avg = (21'(rto) * 21'd9 + 21'(it.elapsed)) / 21'd10;
                        if (avg == 21'd0) avg = 21'd1;
                        rto              = avg[15:0];
                        r.send_kind      = KIND_ACK;
                        r.send_block     = it.block_number;
                        r.arm_timer      = 1'b1;
                        r.timer_value    = rto;
                        r.payload_accept = 1'b1;
                        r.payload_bytes  = datalen;
                        next_block       = next_block + 16'd1;
                        rx_bytes         = rx_bytes + 32'(datalen);
                        retries          = 8'd0;
                        // A block shorter than the full size ends the file.
                        if (datalen < cfg_blk) begin
                            eng_state    = ST_IDLE;
                            r.end_status = END_DONE;
                        end
                    end else if (it.opcode == OP_ERROR && it.packet_length >= MIN_ERR_LEN) begin
                        if (eng_state == ST_ABORT) begin
                            eng_state = ST_IDLE;
                        end else begin
                            eng_state    = ST_ERR;
                            r.end_status = END_PEER;
                        end
                    end
                end
            end
            MODE_TIMER: begin
                if (eng_state == ST_REQ) begin
                    if (retries >= cfg_retries) begin
                        eng_state    = ST_IDLE;
                        r.end_status = END_TIMEOUT;
                    end else begin
                        r.send_kind   = KIND_RRQ;
                        r.arm_timer   = 1'b1;
                        r.timer_value = rto;
                        void'(double_rto());
                        bump_retries();
                    end
                end else if (eng_state == ST_RUN) begin
                    if (retries >= cfg_retries) begin
                        r.end_status  = END_TIMEOUT;
                        eng_state     = ST_ABORT;
                        rto           = 16'd1;
                        retries       = 8'd0;
                        r.arm_timer   = 1'b1;
                        r.timer_value = rto;
                    end else begin
                        r.send_kind  = KIND_ACK;
                        r.send_block = next_block - 16'd1;
                        if (double_rto()) bump_retries();
                        r.arm_timer   = 1'b1;
                        r.timer_value = rto;
                    end
                end else if (eng_state == ST_ABORT) begin
                    if (retries >= cfg_retries) begin
                        eng_state = ST_IDLE;
                    end else begin
                        r.send_kind = KIND_ERROR;
                        if (double_rto()) bump_retries();
                        r.arm_timer   = 1'b1;
                        r.timer_value = rto;
                    end
                end
            end
            default: begin
                if (eng_state == ST_RUN) begin
                    eng_state     = ST_ABORT;
                    rto           = 16'd1;
                    retries       = 8'd0;
                    r.arm_timer   = 1'b1;
                    r.timer_value = rto;
                end else begin
                    eng_state = ST_IDLE;
                end
            end
        endcase
        r.link_state = eng_state;
        return r;
    endfunction

    function automatic t_in_item item(input logic [1:0] mode, input logic [15:0] opcode,
                                      input logic [15:0] blk, input logic [9:0] len,
                                      input logic [15:0] elapsed);
        t_in_item it;
        it.mode          = mode;
        it.opcode        = opcode;
        it.block_number  = blk;
        it.packet_length = len;
        it.elapsed       = elapsed;
        return it;
    endfunction

    function automatic t_out_item res(input logic [1:0] kind, input logic [15:0] sblock,
                                      input logic arm, input logic [15:0] tval,
                                      input logic [2:0] link, input logic acc,
                                      input logic [9:0] pbytes, input logic [1:0] endst);
        t_out_item r;
        r.send_kind      = kind;
        r.send_block     = sblock;
        r.arm_timer      = arm;
        r.timer_value    = tval;
        r.link_state     = link;
        r.payload_accept = acc;
        r.payload_bytes  = pbytes;
        r.end_status     = endst;
        return r;
    endfunction

    // A result that sends nothing and arms nothing.
    function automatic t_out_item silent(input logic [2:0] link, input logic [1:0] endst);
        return res(KIND_NONE, 16'd0, 1'b0, 16'd0, link, 1'b0, 10'd0, endst);
    endfunction

    // Random item, shaped by the current protocol state so that most
    // transfers get past the request and run for a while.
    function automatic t_in_item next_random_item();
        t_in_item    it;
        int unsigned roll;
        int unsigned full_len;
        roll             = $urandom_range(99);
        it.mode          = MODE_PKT;
        it.opcode        = OP_DATA;
        it.block_number  = next_block;
        it.packet_length = 10'd0;
        case ($urandom_range(3))
            0:       it.elapsed = 16'($urandom);
            1:       it.elapsed = 16'($urandom_range(2 * rto + 1));
            2:       it.elapsed = 16'd0;
            default: it.elapsed = 16'($urandom_range(300));
        endcase
        full_len = int'(cfg_blk) + 4;
        if (full_len > 1023) full_len = 1023;
        if (roll < 5 || ((eng_state == ST_IDLE || eng_state == ST_ERR) && roll < 60)) begin
            it = item(MODE_START, 16'($urandom), 16'($urandom), 10'($urandom), it.elapsed);
        end else if (roll < 8) begin
            it = item(MODE_ABORT, 16'($urandom), 16'($urandom), 10'($urandom), it.elapsed);
        end else if (roll < 30) begin
            it = item(MODE_TIMER, 16'($urandom), 16'($urandom), 10'($urandom), it.elapsed);
        end else if (roll < 38) begin
            it = item(2'($urandom), 16'($urandom), 16'($urandom), 10'($urandom),
                      16'($urandom));
        end else if (roll < 44) begin
            // Error packets, now and then with the opcode byte-swapped.
            it.opcode        = ($urandom_range(4) == 0) ? 16'h0500 : OP_ERROR;
            it.packet_length = 10'($urandom_range(8, 2));
        end else if (roll < 50) begin
            it.block_number  = ($urandom_range(1) == 0) ? 16'($urandom)
                                                        : next_block + 16'd1;
            it.packet_length = 10'($urandom_range(1023));
        end else begin
            it.packet_length = ($urandom_range(6) == 0) ? 10'($urandom_range(full_len, 4))
                                                        : 10'(full_len);
        end
        return it;
    endfunction

    task automatic compare_result(input t_out_item want, input t_out_item got);
        if (got.send_kind !== want.send_kind) begin
            $error("send_kind mismatch: expected %0d, actual %0d", want.send_kind, got.send_kind);
            error_count++;
        end
        if (got.send_block !== want.send_block) begin
            $error("send_block mismatch: expected %0d, actual %0d",
                   want.send_block, got.send_block);
            error_count++;
        end
        if (got.arm_timer !== want.arm_timer) begin
            $error("arm_timer mismatch: expected %0d, actual %0d", want.arm_timer, got.arm_timer);
            error_count++;
        end
        if (got.timer_value !== want.timer_value) begin
            $error("timer_value mismatch: expected %0d, actual %0d",
                   want.timer_value, got.timer_value);
            error_count++;
        end
        if (got.link_state !== want.link_state) begin
            $error("link_state mismatch: expected %0d, actual %0d",
                   want.link_state, got.link_state);
            error_count++;
        end
        if (got.payload_accept !== want.payload_accept) begin
            $error("payload_accept mismatch: expected %0d, actual %0d",
                   want.payload_accept, got.payload_accept);
            error_count++;
        end
        if (got.payload_bytes !== want.payload_bytes) begin
            $error("payload_bytes mismatch: expected %0d, actual %0d",
                   want.payload_bytes, got.payload_bytes);
            error_count++;
        end
        if (got.end_status !== want.end_status) begin
            $error("end_status mismatch: expected %0d, actual %0d",
                   want.end_status, got.end_status);
            error_count++;
        end
    endtask

    // Observes both handshakes and the register port at every rising edge.
    // Results are checked before new items are predicted.
    always @(posedge i_clk) begin
        t_out_item  predicted;
        if (!i_rst_n) begin
            cfg_init    = DEF_INITIAL_TIMEOUT;
            cfg_max     = DEF_MAX_TIMEOUT;
            cfg_retries = DEF_MAX_RETRIES;
            cfg_blk     = DEF_BLOCK_BYTES;
            eng_state   = ST_IDLE;
            next_block  = 16'd1;
            rto         = DEF_INITIAL_TIMEOUT;
            retries     = 8'd0;
            rx_bytes    = 32'd0;
        end else begin
            if (pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    $error("result popped with no item outstanding");
                    error_count++;
                end else begin
                    compare_result(awaited_results.pop_front(), o_result);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INITIAL_TIMEOUT: cfg_init    = i_cfg_data;
                    REG_MAX_TIMEOUT:     cfg_max     = i_cfg_data;
                    REG_MAX_RETRIES:     cfg_retries = i_cfg_data[7:0];
                    REG_BLOCK_BYTES:     cfg_blk     = i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            if (push && !full) begin
                predicted = predict_engine_result(i_item);
                // Every accepted item counts toward a phase.
                accepted_items++;
                awaited_results.push_back(row_known ? row_want : predicted);
            end
        end
    end

    // Receiver: switches among random stall styles and serves requests
    // for a long hold-off.
    initial begin : receiver
        int unsigned hold_left;
        int unsigned style;
        int unsigned cyc;
        int          holds_served;
        hold_left    = 0;
        style        = 0;
        cyc          = 0;
        holds_served = 0;
        pop          = 1'b0;
        rx_holding   = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) style = $urandom_range(3);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rx_holding = 1'b1;
                pop <= 1'b0;
            end else begin
                rx_holding = 1'b0;
                case (style)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(1));
                    2:       pop <= (cyc % 4 == 0);
                    default: pop <= ($urandom_range(3) != 0);
                endcase
            end
        end
    end

    // Offers one item, starting at a falling edge, and returns at the falling
    // edge after it was taken.
    task automatic offer(input t_in_item it, input logic known, input t_out_item want);
        push      <= 1'b1;
        i_item    <= it;
        row_known <= known;
        row_want  <= want;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    // No gaps while the receiver holds off, so that the block fills up.
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(40, 1);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
        if (rx_holding) gap = 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_regs(input logic [15:0] init_to, input logic [15:0] max_to,
                              input logic [15:0] max_rt, input logic [15:0] blk_bytes);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_INITIAL_TIMEOUT;
        i_cfg_data  <= init_to;
        @(negedge i_clk);
        i_cfg_index <= REG_MAX_TIMEOUT;
        i_cfg_data  <= max_to;
        @(negedge i_clk);
        i_cfg_index <= REG_MAX_RETRIES;
        i_cfg_data  <= max_rt;
        @(negedge i_clk);
        i_cfg_index <= REG_BLOCK_BYTES;
        i_cfg_data  <= blk_bytes;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Main stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        t_dir_row    rows[$];
        logic [15:0] phase_cfg[N_PHASES][4];
        int          target;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        row_known   = 1'b0;
        row_want    = '0;

        // Directed items under the reset configuration.
        rows.push_back('{item(MODE_TIMER, 16'd0, 16'd0, 10'd0, 16'd0), 1'b1,
                         silent(ST_IDLE, END_NONE)});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd516, 16'd0), 1'b1,
                         silent(ST_IDLE, END_NONE)});
        rows.push_back('{item(MODE_ABORT, 16'd0, 16'd0, 10'd0, 16'd0), 1'b1,
                         silent(ST_IDLE, END_NONE)});
        rows.push_back('{item(MODE_START, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF), 1'b1,
                         res(KIND_RRQ, 16'd0, 1'b1, 16'd4000, ST_REQ, 1'b0, 10'd0, END_NONE)});
        // A packet too short to carry an opcode.
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd1, 16'd0), 1'b1,
                         silent(ST_REQ, END_NONE)});
        rows.push_back('{item(MODE_TIMER, 16'd0, 16'd0, 10'd0, 16'd0), 1'b1,
                         res(KIND_RRQ, 16'd0, 1'b1, 16'd8000, ST_REQ, 1'b0, 10'd0, END_NONE)});
        // Out-of-sequence block, then a data packet with a truncated header.
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd2, 10'd516, 16'd0), 1'b1,
                         silent(ST_REQ, END_NONE)});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd3, 16'd0), 1'b1,
                         silent(ST_REQ, END_NONE)});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd516, 16'd100), 1'b1,
                         res(KIND_ACK, 16'd1, 1'b1, 16'd14410, ST_RUN, 1'b1, 10'd512,
                             END_NONE)});
        rows.push_back('{item(MODE_PKT, 16'd7, 16'd1, 10'd100, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_TIMER, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd2, 10'h3FF, 16'hFFFF), 1'b0, '0});
        rows.push_back('{item(MODE_ABORT, 16'd0, 16'd0, 10'd0, 16'd0), 1'b1,
                         res(KIND_NONE, 16'd0, 1'b1, 16'd1, ST_ABORT, 1'b0, 10'd0, END_NONE)});
        // While aborting, data is ignored and an error packet needs five bytes.
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd3, 10'd516, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_TIMER, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_ERROR, 16'd0, 10'd4, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_ERROR, 16'd0, 10'd5, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_START, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_ERROR, 16'd0, 10'd5, 16'd0), 1'b1,
                         silent(ST_ERR, END_PEER)});
        rows.push_back('{item(MODE_TIMER, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd516, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_ABORT, 16'd0, 16'd0, 10'd0, 16'd0), 1'b1,
                         silent(ST_IDLE, END_NONE)});
        // An empty last block ends the file.
        rows.push_back('{item(MODE_START, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd4, 16'd0), 1'b0, '0});
        // Restart in the middle of a transfer.
        rows.push_back('{item(MODE_START, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_PKT, OP_DATA, 16'd1, 10'd516, 16'd0), 1'b0, '0});
        rows.push_back('{item(MODE_START, 16'd0, 16'd0, 10'd0, 16'd0), 1'b0, '0});
        // Error opcode in the wrong byte order is not an error packet.
        rows.push_back('{item(MODE_PKT, 16'h0500, 16'd0, 10'd5, 16'd0), 1'b0, '0});

        // Register settings per phase: initial, ceiling, retries, block size.
        phase_cfg[0] = '{16'd1, 16'd1, 16'd1, 16'd1};
        phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_cfg[2] = '{16'd0, 16'd0, 16'd0, 16'd0};
        phase_cfg[3] = '{16'd4000, 16'd16000, 16'd8, 16'd512};
        phase_cfg[4] = '{16'd100, 16'd3000, 16'd4, 16'd16};
        phase_cfg[5] = '{16'd5000, 16'd1000, 16'd3, 16'd64};
        phase_cfg[6] = '{16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                         16'($urandom_range(255, 1)), 16'($urandom_range(512, 1))};
        phase_cfg[7] = '{16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                         16'($urandom_range(255, 1)), 16'($urandom_range(512, 1))};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            offer(rows[k].stim, rows[k].known, rows[k].want);
            pace();
        end

        for (int p = 0; p < N_PHASES; p++) begin
            push <= 1'b0;
            while (awaited_results.size() != 0) @(negedge i_clk);
            write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            if (p == 1 || p == 4) hold_requests++;
            target = accepted_items + ITEMS_PER_PHASE;
            while (accepted_items < target) begin
                offer(next_random_item(), 1'b0, '0);
                pace();
            end
        end

        // Drain the remaining results, then allow for the pipeline latency.
        push <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
